@@ hw/rtl/triangle_barycentric_weights_assert.svh @@
// Assertion macros for the triangle barycentric weights block.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_ASSERT_SVH
`ifndef SYNTHESIS
`define TBW_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TBW_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/tbw_pkg.sv @@
// Shared constants for the triangle barycentric weights block.
`timescale 1ns / 1ps
`default_nettype none
package tbw_pkg;
  localparam int unsigned IntBits = 2;
endpackage
`default_nettype wire

@@ hw/rtl/tbw_if.sv @@
// Valid/ready channel interfaces for vertex input and weight output.
`timescale 1ns / 1ps
`default_nettype none
interface tbw_in_if #(parameter int COORD_WIDTH = 16) (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_WIDTH-1:0] third_x, third_y, point_x, point_y;
  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  point_x, point_y, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                point_x, point_y, output ready);
endinterface

interface tbw_out_if #(parameter int WEIGHT_WIDTH = 16) (input wire logic clk);
  logic valid;
  logic ready;
  logic [WEIGHT_WIDTH-1:0] weight_first, weight_second, weight_third;
  logic degenerate;
  logic saturated;
  modport source (output valid, weight_first, weight_second, weight_third, degenerate,
                  saturated, input ready);
  modport sink (input valid, weight_first, weight_second, weight_third, degenerate,
                saturated, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/triangle_barycentric_weights.sv @@
// Top level: pipelined barycentric weights by area ratio.
// Each beat passes the product, area and divider stage registers; one beat per cycle
// unless the output stalls, and each quotient bit has its own restoring stage.
// The whole pipeline advances together; a stalled output freezes every stage.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_barycentric_weights_assert.svh"
module triangle_barycentric_weights #(
  parameter int COORD_WIDTH = 16,
  parameter int WEIGHT_FRAC_BITS = 14
) (
  input wire logic clk,
  input wire logic rst_n,
  tbw_in_if.sink in_ch,
  tbw_out_if.source out_ch
);
  localparam int WW = WEIGHT_FRAC_BITS + tbw_pkg::IntBits;
  localparam int DW = COORD_WIDTH + 1;          // coordinate difference width
  localparam int AW = 2 * DW + 1;               // doubled area magnitude width
  localparam int RW = AW + 2;                   // remainder and divisor width
  localparam int NQ = WEIGHT_FRAC_BITS + 3;     // saturation check plus quotient bits
  localparam int NS = 2 + NQ;                   // total stages

  // One global enable: everything moves when the output slot is free or empty.
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
    end
  end

  // Stage 0: edge differences for the four areas, and the eight products.
  // Each area is |ux*vy - vx*uy|; the products are registered before the subtract.
  logic signed [DW-1:0] ux [4], uy [4], vx [4], vy [4];
  logic signed [2*DW-1:0] pa_r [4], pb_r [4];
  logic signed [DW-1:0] ax [4], ay [4], bx [4], by [4], cx [4], cy [4];
  always_comb begin
    ax[0] = DW'(in_ch.first_x);  ay[0] = DW'(in_ch.first_y);
    bx[0] = DW'(in_ch.second_x); by[0] = DW'(in_ch.second_y);
    cx[0] = DW'(in_ch.third_x);  cy[0] = DW'(in_ch.third_y);
    ax[1] = DW'(in_ch.point_x);  ay[1] = DW'(in_ch.point_y);
    bx[1] = bx[0]; by[1] = by[0]; cx[1] = cx[0]; cy[1] = cy[0];
    ax[2] = ax[1]; ay[2] = ay[1];
    bx[2] = cx[0]; by[2] = cy[0]; cx[2] = ax[0]; cy[2] = ay[0];
    ax[3] = ax[1]; ay[3] = ay[1];
    bx[3] = ax[0]; by[3] = ay[0]; cx[3] = bx[0]; cy[3] = by[0];
    for (int k = 0; k < 4; k++) begin
      ux[k] = bx[k] - ax[k];
      uy[k] = by[k] - ay[k];
      vx[k] = cx[k] - ax[k];
      vy[k] = cy[k] - ay[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= (2*DW)'(ux[k]) * (2*DW)'(vy[k]);
        pb_r[k] <= (2*DW)'(vx[k]) * (2*DW)'(uy[k]);
      end
    end
  end

  // Stage 1: subtract and take the magnitude.
  logic signed [AW-1:0] dif [4];
  logic [AW-1:0] area_r [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dif[k] = AW'(pa_r[k]) - AW'(pb_r[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        area_r[k] <= dif[k][AW-1] ? AW'(-dif[k]) : AW'(dif[k]);
      end
    end
  end

  // Divider stages: stage 0 tests part >= 4*full, then one restoring step per
  // quotient bit; the first integer bit compares against full shifted left.
  logic [RW-1:0] full_r [NQ];
  logic [RW-1:0] rem_r  [NQ][3];
  logic [WW-1:0] q_r    [NQ][3];
  logic          sat_r  [NQ][3];
  logic          deg_r  [NQ];

  always_ff @(posedge clk) begin
    if (adv) begin
      full_r[0] <= RW'(area_r[0]);
      deg_r[0] <= (area_r[0] == '0);
      for (int j = 0; j < 3; j++) begin
        rem_r[0][j] <= RW'(area_r[j+1]);
        q_r[0][j] <= '0;
        sat_r[0][j] <= (RW'(area_r[j+1]) >= (RW'(area_r[0]) << 2));
      end
      for (int s = 1; s < NQ; s++) begin
        full_r[s] <= full_r[s-1];
        deg_r[s] <= deg_r[s-1];
        for (int j = 0; j < 3; j++) begin
          logic [RW-1:0] trial;
          logic [RW-1:0] cur;
          trial = (s == 1) ? (full_r[s-1] << 1) : full_r[s-1];
          cur = (s <= 2) ? rem_r[s-1][j] : (rem_r[s-1][j] << 1);
          sat_r[s][j] <= sat_r[s-1][j];
          if (cur >= trial) begin
            rem_r[s][j] <= cur - trial;
            q_r[s][j] <= (q_r[s-1][j] << 1) | WW'(1);
          end else begin
            rem_r[s][j] <= cur;
            q_r[s][j] <= q_r[s-1][j] << 1;
          end
        end
      end
    end
  end

  // Output formatting: degenerate forces all ones, saturation clamps.
  logic [WW-1:0] wout [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wout[j] = (deg_r[NQ-1] || sat_r[NQ-1][j]) ? '1 : q_r[NQ-1][j];
    end
  end
  assign out_ch.valid = vld_r[NS-1];
  assign out_ch.weight_first = wout[0];
  assign out_ch.weight_second = wout[1];
  assign out_ch.weight_third = wout[2];
  assign out_ch.degenerate = deg_r[NQ-1];
  assign out_ch.saturated = !deg_r[NQ-1] &&
                            (sat_r[NQ-1][0] || sat_r[NQ-1][1] || sat_r[NQ-1][2]);

  `TBW_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "lost beat")
  `TBW_ASSERT_IMPL(a_flags, clk, rst_n, !(out_ch.valid && out_ch.degenerate && out_ch.saturated), "both flags")
  `TBW_ASSERT_IMPL(a_rdy, clk, rst_n, out_ch.ready || !out_ch.valid || !in_ch.ready, "ready while stalled")
endmodule
`default_nettype wire

@@ bench/triangle_barycentric_weights_tb.sv @@
// Self-checking testbench for the triangle barycentric weights pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard that predicts the weights of each accepted beat and checks results in order.
class weight_scoreboard;
  typedef struct packed {
    logic [15:0] w_first;
    logic [15:0] w_second;
    logic [15:0] w_third;
    logic        degenerate;
    logic        saturated;
  } weights_t;

  weights_t pending[$];
  int errors;
  int mismatches;

  // Absolute doubled area. Coordinates are 16-bit, so every product fits in 40 bits.
  static function automatic logic [63:0] area2(
      longint ax, longint ay, longint bx, longint by, longint cx, longint cy);
    longint xprod;
    xprod = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    return xprod < 0 ? -xprod : xprod;
  endfunction

  // Floor of part * 2^14 / full, clamped to the largest code at four or more.
  static function automatic logic [15:0] weight_of(
      logic [63:0] part, logic [63:0] full, inout logic sat);
    logic [63:0] q;
    if (part >= (full << 2)) begin
      sat = 1'b1;
      return 16'hffff;
    end
    q = (part << 14) / full;
    return q[15:0];
  endfunction

  function void note_input(logic signed [15:0] c[8]);
    weights_t w;
    logic [63:0] full;
    logic sat;
    sat = 1'b0;
    full = area2(c[0], c[1], c[2], c[3], c[4], c[5]);
    if (full == 0) begin
      w = '{16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0};
    end else begin
      w.w_first = weight_of(area2(c[6], c[7], c[2], c[3], c[4], c[5]), full, sat);
      w.w_second = weight_of(area2(c[6], c[7], c[4], c[5], c[0], c[1]), full, sat);
      w.w_third = weight_of(area2(c[6], c[7], c[0], c[1], c[2], c[3]), full, sat);
      w.degenerate = 1'b0;
      w.saturated = sat;
    end
    pending.push_back(w);
  endfunction

  function void check_result(weights_t got);
    weights_t want;
    if (pending.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result beat %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (mismatches++ < 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module triangle_barycentric_weights_tb;
  localparam int IdleLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  // Once set, neither side inserts idle cycles any more.
  logic steady = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  tbw_in_if #(.COORD_WIDTH(16)) in_ch (clk);
  tbw_out_if #(.WEIGHT_WIDTH(16)) out_ch (clk);

  triangle_barycentric_weights u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  weight_scoreboard board = new();

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.first_x, in_ch.first_y, in_ch.second_x, in_ch.second_y} = '0;
    {in_ch.third_x, in_ch.third_y, in_ch.point_x, in_ch.point_y} = '0;
    out_ch.ready = 1'b0;
  end

  // Accepted input beats feed the predictor; accepted result beats are checked at the
  // same rising edge, so the ordering of the two never matters for a single pipeline.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        logic signed [15:0] c[8];
        c = '{in_ch.first_x, in_ch.first_y, in_ch.second_x, in_ch.second_y,
              in_ch.third_x, in_ch.third_y, in_ch.point_x, in_ch.point_y};
        board.note_input(c);
      end
      if (out_ch.valid && out_ch.ready)
        board.check_result('{out_ch.weight_first, out_ch.weight_second,
                             out_ch.weight_third, out_ch.degenerate, out_ch.saturated});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: the run is stuck if no beat moves for a long stretch.
  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the final stretch.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Presents one beat at a falling edge and holds it until the block takes it.
  task automatic send_triangle(logic signed [15:0] c[8]);
    int gap;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.first_x, in_ch.first_y, in_ch.second_x, in_ch.second_y} <= {c[0], c[1], c[2], c[3]};
    {in_ch.third_x, in_ch.third_y, in_ch.point_x, in_ch.point_y} <= {c[4], c[5], c[6], c[7]};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Random beat: full-range noise, random coordinates within a small or a wider span,
  // degenerate collinear sets, or slivers that drive weights into saturation.
  task automatic send_random();
    logic signed [15:0] c[8];
    int kind;
    int span;
    kind = $urandom_range(0, 9);
    foreach (c[i]) c[i] = 16'($urandom);
    if (kind < 5) begin
      span = $urandom_range(0, 1) ? 16'h0400 : 16'h3fff;
      foreach (c[i]) c[i] = 16'(int'($urandom_range(0, 2 * span)) - span);
    end else if (kind == 5) begin
      // Collinear: the third vertex lies on the line through the first two.
      c[2] = c[0] + 16'sd7;
      c[3] = c[1] + 16'sd3;
      c[4] = c[0] + 16'sd21;
      c[5] = c[1] + 16'sd9;
    end else if (kind == 6) begin
      // Sliver of doubled area one with a far point.
      c[0] = 0; c[1] = 0; c[2] = 1; c[3] = 0; c[4] = 0; c[5] = 1;
    end
    send_triangle(c);
  endtask

  initial begin
    logic signed [15:0] c[8];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: unit triangle with point at each vertex, center and outside.
    c = '{0, 0, 256, 0, 0, 256, 0, 0};        send_triangle(c);
    c = '{0, 0, 256, 0, 0, 256, 256, 0};      send_triangle(c);
    c = '{0, 0, 256, 0, 0, 256, 0, 256};      send_triangle(c);
    c = '{0, 0, 256, 0, 0, 256, 85, 85};      send_triangle(c);
    c = '{0, 0, 256, 0, 0, 256, -512, 300};   send_triangle(c);
    // Zero-area triangles: all vertices equal, and three on a line.
    c = '{100, 100, 100, 100, 100, 100, 5, 5}; send_triangle(c);
    c = '{0, 0, 10, 10, 20, 20, 3, 7};        send_triangle(c);
    // Weight of exactly four relative to area one, and 3.5, just below four, on a larger triangle.
    c = '{0, 0, 1, 0, 0, 1, 4, 0};            send_triangle(c);
    c = '{0, 0, 2, 0, 0, 2, 7, 0};            send_triangle(c);
    // Coordinate extremes in both signs.
    c = '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}; send_triangle(c);
    c = '{32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768}; send_triangle(c);
    c = '{-32768, 0, 32767, 0, 0, 32767, 0, -32768};                   send_triangle(c);
    c = '{-1, -1, -1, 32767, 32767, -1, 0, 0};                         send_triangle(c);
    // Clockwise winding gives the same weights as counterclockwise.
    c = '{0, 0, 0, 256, 256, 0, 64, 64};      send_triangle(c);

    repeat (1000) send_random();
    steady = 1'b1;
    repeat (150) send_random();
    in_ch.valid <= 1'b0;

    // Drain: wait until every predicted result has been checked.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tbw_pkg.sv
hw/rtl/tbw_if.sv
hw/rtl/triangle_barycentric_weights.sv
bench/triangle_barycentric_weights_tb.sv
